>>> design/sfd_pkg.sv
package sfd_pkg;

  localparam int unsigned SESSIONS_DEF     = 16;
  localparam int unsigned QUERY_FLOATS_DEF = 128;

  localparam int unsigned SID_W   = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned PEND_W  = 24;
  localparam int unsigned TOTAL_W = 64;
  localparam int unsigned SLOT_W  = 4;

  // 64 bytes per data word, 16 floats per data word
  localparam int unsigned WORD_SHIFT  = 6;
  localparam int unsigned FLOAT_SHIFT = 4;
  localparam int unsigned FLOAT_W     = LEN_W - WORD_SHIFT + FLOAT_SHIFT;

  typedef struct packed {
    logic added;
    logic full;
  } lk_res_t;

endpackage

>>> design/session_fifo_dispatcher_unit.sv
// Packet header bookkeeping for up to SESSIONS sessions. Each header (session ID in
// s_axis_tdata[15:0], byte length in [31:16]) gives exactly one result transaction.
// A header takes longer the later its session sits in the table, plus any output stall:
// the session-ID table is scanned one entry per cycle through its memory, then the
// session's pending float count is read, updated and written back. A new header is
// taken once the previous one has been handed to the output register.
// A session not in the table is added in the next free slot; with the table full
// the header sets table_full and adds no floats, but its bytes still count toward
// the running total that drives all_received. Write expected_bytes only while idle.
module session_fifo_dispatcher_unit #(
  parameter int unsigned SESSIONS     = sfd_pkg::SESSIONS_DEF,
  parameter int unsigned QUERY_FLOATS = sfd_pkg::QUERY_FLOATS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [63:0] cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] sess_id, [31:16] pkt_len
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] slot, [4] new_session, [5] query_ready, [21:6] ready_session,
  // [22] all_received, [23] table_full
  output logic [23:0] m_axis_tdata
);
  import sfd_pkg::*;

  localparam int unsigned IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_PEND = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [SID_W-1:0]   sid_q;
  logic [LEN_W-1:0]   len_q;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] expected_q;
  logic [IDX_W-1:0]   slot_q;
  logic               added_q, full_q, ready_q;
  logic               m_valid_q;
  logic [23:0]        m_data_q;

  logic               accept, load_out;
  logic               lk_done;
  logic [IDX_W-1:0]   lk_slot;
  lk_res_t            lk_res;
  logic               pd_start, pd_done, pd_ready;
  logic [FLOAT_W-1:0] floats;
  logic [IDX_W+3:0]   slot_ext;
  logic [SLOT_W-1:0]  slot_out;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_out      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
  assign pd_start      = (state_q == ST_LOOK) && lk_done && !lk_res.full;
  assign floats        = {len_q[LEN_W-1:WORD_SHIFT], {FLOAT_SHIFT{1'b0}}};

  assign total_sum = {1'b0, total_q} + (TOTAL_W+1)'(s_axis_tdata[31:16]);
  assign total_d   = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

  assign slot_ext = (IDX_W+4)'(slot_q);
  assign slot_out = full_q ? '0 : slot_ext[SLOT_W-1:0];

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  sfd_lookup #(
    .SESSIONS (SESSIONS),
    .IDX_W    (IDX_W)
  ) u_lookup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .sid_i   (s_axis_tdata[15:0]),
    .done_o  (lk_done),
    .slot_o  (lk_slot),
    .res_o   (lk_res)
  );

  sfd_pending #(
    .SESSIONS     (SESSIONS),
    .QUERY_FLOATS (QUERY_FLOATS),
    .IDX_W        (IDX_W)
  ) u_pending (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (pd_start),
    .slot_i   (lk_slot),
    .floats_i (floats),
    .done_o   (pd_done),
    .ready_o  (pd_ready)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (lk_done) begin
          state_d = lk_res.full ? ST_DONE : ST_PEND;
        end
      end
      ST_PEND: begin
        if (pd_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      total_q    <= '0;
      expected_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        total_q <= total_d;
      end
      if (cfg_wr_en_i) begin
        expected_q <= cfg_wr_data_i;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sid_q <= s_axis_tdata[15:0];
      len_q <= s_axis_tdata[31:16];
    end
    if ((state_q == ST_LOOK) && lk_done) begin
      slot_q  <= lk_slot;
      added_q <= lk_res.added;
      full_q  <= lk_res.full;
      ready_q <= 1'b0;
    end
    if ((state_q == ST_PEND) && pd_done) begin
      ready_q <= pd_ready;
    end
    if (load_out) begin
      m_data_q <= {full_q, (total_q >= expected_q), (ready_q ? sid_q : {SID_W{1'b0}}),
                   ready_q, added_q, slot_out};
    end
  end

endmodule

>>> design/sfd_lookup.sv
module sfd_lookup #(
  parameter int unsigned SESSIONS = sfd_pkg::SESSIONS_DEF,
  parameter int unsigned IDX_W    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [sfd_pkg::SID_W-1:0] sid_i,
  output logic                    done_o,
  output logic [IDX_W-1:0]        slot_o,
  output sfd_pkg::lk_res_t        res_o
);
  import sfd_pkg::*;

  localparam int unsigned CNT_W = $clog2(SESSIONS + 1);

  logic [SID_W-1:0] id_mem [SESSIONS];
  logic [SID_W-1:0] rd_data_q;
  logic [SID_W-1:0] sid_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             busy_q, busy_d;
  logic             cmp_q, cmp_d;
  logic             hit, more, room, rd_en, wr_en;

  assign hit   = busy_q && cmp_q && (rd_data_q == sid_q);
  assign more  = scan_q < count_q;
  assign room  = count_q < CNT_W'(SESSIONS);
  assign rd_en = busy_q && !hit && more;

  assign done_o      = busy_q && (hit || !more);
  assign wr_en       = done_o && !hit && room;
  assign slot_o      = hit ? cmp_idx_q : count_q[IDX_W-1:0];
  assign res_o.added = done_o && !hit && room;
  assign res_o.full  = done_o && !hit && !room;

  always_comb begin
    busy_d    = busy_q;
    scan_d    = scan_q;
    cmp_d     = cmp_q;
    cmp_idx_d = cmp_idx_q;
    count_d   = count_q;
    if (start_i) begin
      busy_d = 1'b1;
      scan_d = '0;
      cmp_d  = 1'b0;
    end else if (done_o) begin
      busy_d = 1'b0;
      cmp_d  = 1'b0;
      if (wr_en) begin
        count_d = count_q + CNT_W'(1);
      end
    end else if (rd_en) begin
      cmp_d     = 1'b1;
      cmp_idx_d = scan_q[IDX_W-1:0];
      scan_d    = scan_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cmp_q     <= 1'b0;
      scan_q    <= '0;
      cmp_idx_q <= '0;
      count_q   <= '0;
    end else begin
      busy_q    <= busy_d;
      cmp_q     <= cmp_d;
      scan_q    <= scan_d;
      cmp_idx_q <= cmp_idx_d;
      count_q   <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sid_q <= sid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= id_mem[scan_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      id_mem[count_q[IDX_W-1:0]] <= sid_q;
    end
  end

endmodule

>>> design/sfd_pending.sv
module sfd_pending #(
  parameter int unsigned SESSIONS     = sfd_pkg::SESSIONS_DEF,
  parameter int unsigned QUERY_FLOATS = sfd_pkg::QUERY_FLOATS_DEF,
  parameter int unsigned IDX_W        = (SESSIONS > 1) ? $clog2(SESSIONS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [IDX_W-1:0]            slot_i,
  input  logic [sfd_pkg::FLOAT_W-1:0] floats_i,
  output logic                        done_o,
  output logic                        ready_o
);
  import sfd_pkg::*;

  logic [PEND_W-1:0]  pend_mem [SESSIONS];
  logic [PEND_W-1:0]  rd_data_q;
  logic               rd_vld_q;
  logic [SESSIONS-1:0] valid_q;
  logic               ph_q;
  logic [IDX_W-1:0]   slot_q;
  logic [FLOAT_W-1:0] floats_q;
  logic [PEND_W-1:0]  cur, sat, wr_data;
  logic [PEND_W:0]    sum;

  assign cur     = rd_vld_q ? rd_data_q : '0;
  assign sum     = {1'b0, cur} + (PEND_W+1)'(floats_q);
  assign sat     = sum[PEND_W] ? '1 : sum[PEND_W-1:0];
  assign ready_o = ph_q && (sat >= PEND_W'(QUERY_FLOATS));
  assign wr_data = ready_o ? (sat - PEND_W'(QUERY_FLOATS)) : sat;
  assign done_o  = ph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= 1'b0;
      valid_q <= '0;
    end else begin
      ph_q <= start_i;
      if (ph_q) begin
        valid_q[slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      slot_q    <= slot_i;
      floats_q  <= floats_i;
      rd_vld_q  <= valid_q[slot_i];
      rd_data_q <= pend_mem[slot_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_q) begin
      pend_mem[slot_q] <= wr_data;
    end
  end

endmodule
